// File: hw/rtl/gasp_pkg.sv
// shared types and constants for the glyph atlas shelf packer
// used by gasp_ctrl, gasp_dpath, the top level and the checker
`default_nettype none

package gasp_pkg;

   localparam int GASP_MAX_GLYPH_SIDE = 256;
   localparam int FIRST_PRINTABLE     = 32;
   localparam int HEIGHT_CAP          = 16383;
   localparam int PEN_Y_CAP           = 16383;
   localparam int PLACE_X_CAP         = 4095;
   localparam int PLACE_Y_CAP         = 8191;
   localparam int DOUBLE_LIMIT        = 14;

   localparam int RESET_ATLAS_WIDTH   = 512;
   localparam int RESET_START_HEIGHT  = 64;
   localparam int RESET_MAX_HEIGHT    = 4096;

   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 14;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATLAS_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_HEIGHT   = 2'd2;

   localparam int REQ_DATA_WIDTH      = 40;
   localparam int RSP_DATA_WIDTH      = 40;

   typedef enum logic [1:0] {
      GASP_IDLE,
      GASP_WRAP,
      GASP_GROW,
      GASP_FINISH
   } gasp_state_type;

   // commands from controller to datapath, at most one per cycle
   typedef struct packed {
      logic load;
      logic wrap;
      logic grow;
      logic finish;
   } gasp_cmd_type;

   typedef struct packed {
      logic skip;
      logic need_grow;
   } gasp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/gasp_ctrl.sv
// sequencing state machine of the shelf packer: load, wrap, grow, finish
// depends on gasp_pkg; drives commands into gasp_dpath
`default_nettype none

module gasp_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire gasp_pkg::gasp_status_type status,
   output gasp_pkg::gasp_cmd_type         cmd
);

   gasp_pkg::gasp_state_type state_ff, state_in;
   logic [3:0]               count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gasp_pkg::GASP_IDLE;
         count_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         gasp_pkg::GASP_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = gasp_pkg::GASP_WRAP;
            end
         end
         gasp_pkg::GASP_WRAP: begin
            cmd.wrap = 1'b1;
            count_in = 4'd0;
            state_in = gasp_pkg::GASP_GROW;
         end
         gasp_pkg::GASP_GROW: begin
            // one doubling per cycle
            if (!status.skip && status.need_grow &&
                count_ff < 4'(gasp_pkg::DOUBLE_LIMIT)) begin
               cmd.grow = 1'b1;
               count_in = count_ff + 4'd1;
            end else begin
               state_in = gasp_pkg::GASP_FINISH;
            end
         end
         gasp_pkg::GASP_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = gasp_pkg::GASP_IDLE;
            end
         end
         default: begin
            state_in = gasp_pkg::GASP_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gasp_dpath.sv
// datapath of the shelf packer: config, pen and atlas state, result register
// depends on gasp_pkg; driven by commands from gasp_ctrl
`default_nettype none

module gasp_dpath #(
   parameter int MAX_GLYPH_SIDE = gasp_pkg::GASP_MAX_GLYPH_SIDE
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   input  wire logic [gasp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [gasp_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   input  wire logic [gasp_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  wire logic                                   req_tuser,
   input  wire logic                                   req_tlast,
   output logic [gasp_pkg::RSP_DATA_WIDTH-1:0]         rsp_tdata,
   output logic                                        rsp_tuser,
   output logic                                        rsp_tlast,
   input  wire gasp_pkg::gasp_cmd_type                 cmd,
   output gasp_pkg::gasp_status_type                   status
);

   logic [12:0] atlas_width_ff, atlas_width_in;
   logic [12:0] start_height_ff, start_height_in;
   logic [13:0] max_height_ff, max_height_in;

   logic [12:0] pen_x_ff, pen_x_in;
   logic [13:0] pen_y_ff, pen_y_in;
   logic [8:0]  row_ff, row_in;
   logic [13:0] height_ff, height_in;

   logic [8:0]  bw_ff, bh_ff;
   logic        skip_ff, last_ff;

   logic [11:0] px_ff;
   logic [12:0] py_ff;
   logic [13:0] hnow_ff;
   logic        placed_ff, done_ff;

   logic [20:0] cp_new;
   logic [8:0]  bw_new, bh_new;
   logic        skip_new;
   logic [13:0] right_edge;
   logic [14:0] wrap_y;
   logic [13:0] wrap_y_sat;
   logic [14:0] bottom;
   logic [14:0] dbl;
   logic        fits, placed;
   logic [11:0] px_sat;
   logic [12:0] py_sat;

   always_comb begin
      cp_new   = req_tdata[20:0];
      bw_new   = (req_tdata[29:21] == 9'd0) ? 9'd1 : req_tdata[29:21];
      bh_new   = (req_tdata[38:30] == 9'd0) ? 9'd1 : req_tdata[38:30];
      skip_new = (cp_new < 21'(gasp_pkg::FIRST_PRINTABLE)) || !req_tuser ||
                 (32'(bw_new) > 32'(MAX_GLYPH_SIDE)) ||
                 (32'(bh_new) > 32'(MAX_GLYPH_SIDE));

      right_edge = {1'b0, pen_x_ff} + {5'd0, bw_ff} + 14'd1;
      wrap_y     = {1'b0, pen_y_ff} + {6'd0, row_ff} + 15'd1;
      wrap_y_sat = (wrap_y > 15'(gasp_pkg::PEN_Y_CAP)) ?
                   14'(gasp_pkg::PEN_Y_CAP) : wrap_y[13:0];
      bottom     = {1'b0, pen_y_ff} + {6'd0, bh_ff} + 15'd1;
      dbl        = {height_ff, 1'b0};
      fits       = bottom <= {1'b0, height_ff};
      placed     = !skip_ff && fits;
      px_sat     = (pen_x_ff > 13'(gasp_pkg::PLACE_X_CAP)) ?
                   12'(gasp_pkg::PLACE_X_CAP) : pen_x_ff[11:0];
      py_sat     = (pen_y_ff > 14'(gasp_pkg::PLACE_Y_CAP)) ?
                   13'(gasp_pkg::PLACE_Y_CAP) : pen_y_ff[12:0];

      status.skip      = skip_ff;
      status.need_grow = (bottom > {1'b0, height_ff}) && (height_ff < max_height_ff);
   end

   // config writes
   always_comb begin
      atlas_width_in  = atlas_width_ff;
      start_height_in = start_height_ff;
      max_height_in   = max_height_ff;
      if (csr_valid) begin
         case (csr_index)
            gasp_pkg::CSR_ATLAS_WIDTH:  atlas_width_in  = csr_data[12:0];
            gasp_pkg::CSR_START_HEIGHT: start_height_in = csr_data[12:0];
            gasp_pkg::CSR_MAX_HEIGHT:   max_height_in   = csr_data;
            default: ;
         endcase
      end
   end

   // pen, row and atlas height
   always_comb begin
      pen_x_in  = pen_x_ff;
      pen_y_in  = pen_y_ff;
      row_in    = row_ff;
      height_in = height_ff;
      if (cmd.wrap && !skip_ff && right_edge > {1'b0, atlas_width_ff}) begin
         pen_x_in = 13'd1;
         pen_y_in = wrap_y_sat;
         row_in   = 9'd0;
      end
      if (cmd.grow) begin
         height_in = (dbl > 15'(gasp_pkg::HEIGHT_CAP)) ?
                     14'(gasp_pkg::HEIGHT_CAP) : dbl[13:0];
      end
      if (cmd.finish) begin
         if (placed) begin
            pen_x_in = right_edge[12:0];
            if (bh_ff > row_ff) begin
               row_in = bh_ff;
            end
         end
         if (last_ff) begin
            pen_x_in  = 13'd1;
            pen_y_in  = 14'd1;
            row_in    = 9'd0;
            height_in = {1'b0, start_height_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_width_ff  <= 13'(gasp_pkg::RESET_ATLAS_WIDTH);
         start_height_ff <= 13'(gasp_pkg::RESET_START_HEIGHT);
         max_height_ff   <= 14'(gasp_pkg::RESET_MAX_HEIGHT);
         pen_x_ff        <= 13'd1;
         pen_y_ff        <= 14'd1;
         row_ff          <= 9'd0;
         height_ff       <= 14'(gasp_pkg::RESET_START_HEIGHT);
      end else begin
         atlas_width_ff  <= atlas_width_in;
         start_height_ff <= start_height_in;
         max_height_ff   <= max_height_in;
         pen_x_ff        <= pen_x_in;
         pen_y_ff        <= pen_y_in;
         row_ff          <= row_in;
         height_ff       <= height_in;
      end
   end

   // request and result payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bw_ff   <= bw_new;
         bh_ff   <= bh_new;
         skip_ff <= skip_new;
         last_ff <= req_tlast;
      end
      if (cmd.finish) begin
         placed_ff <= placed;
         px_ff     <= placed ? px_sat : 12'd0;
         py_ff     <= placed ? py_sat : 13'd0;
         hnow_ff   <= height_ff;
         done_ff   <= last_ff;
      end
   end

   assign rsp_tdata = {1'b0, hnow_ff, py_ff, px_ff};
   assign rsp_tuser = placed_ff;
   assign rsp_tlast = done_ff;

endmodule

`default_nettype wire

// File: hw/rtl/glyph_atlas_shelf_packer.sv
// glyph atlas shelf packer: next-fit shelf placement of glyph boxes
// a request passes wrap, grow (one doubling per cycle, up to DOUBLE_LIMIT) and finish
// requests are taken only in idle; finish stalls while an untaken result is held
// a finished result waits in the output register while the next request is taken
// reset (synchronous, high): state, config and pen registers to defaults, pen at (1,1), atlas height 64
// depends on gasp_pkg, gasp_ctrl and gasp_dpath
`default_nettype none

module glyph_atlas_shelf_packer #(
   parameter int MAX_GLYPH_SIDE = gasp_pkg::GASP_MAX_GLYPH_SIDE
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [gasp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [gasp_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   // request channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // code_point[20:0], box_width[29:21], box_height[38:30], zero[39]
   input  wire logic [gasp_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // metrics_ok
   input  wire logic                                 req_tuser,
   // last_glyph
   input  wire logic                                 req_tlast,
   // result channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // place_x[11:0], place_y[24:12], atlas_height_now[38:25], zero[39]
   output logic [gasp_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // placed
   output logic                                      rsp_tuser,
   // build_done
   output logic                                      rsp_tlast
);

   gasp_pkg::gasp_cmd_type    cmd;
   gasp_pkg::gasp_status_type status;

   // config registers take a write in any cycle
   assign csr_ready = 1'b1;

   // sequencer: idle -> wrap -> grow (repeats per doubling) -> finish
   gasp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // state, arithmetic and the output register
   gasp_dpath #(
      .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// File: hw/rtl/gasp_checker.sv
// port-level checks of the shelf packer, bound to the top level
// depends on glyph_atlas_shelf_packer and gasp_pkg
`default_nettype none

module gasp_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [gasp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input wire logic                                rsp_tuser
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // one request at a time: no new request right after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous still in work");

   // a rejected or skipped glyph reports position zero
   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[24:0] == 25'd0)
      else $error("unplaced glyph with nonzero position");

   // pen row never drops below one, so a placed glyph has nonzero row
   a_placed_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[24:12] != 13'd0)
      else $error("placed glyph at row zero");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind glyph_atlas_shelf_packer gasp_checker u_gasp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: test/glyph_atlas_shelf_packer_test.sv
`timescale 1ns / 1ps
// self-checking testbench for glyph_atlas_shelf_packer: shelf placement of glyph boxes
// keeps its own placement predictor in a small scoreboard class; depends on gasp_pkg and the rtl

module glyph_atlas_shelf_packer_test;
   import gasp_pkg::*;

   localparam int SETTLE_CYCLES   = 24;      // slowest request, with all doublings, plus margin
   localparam int DRAIN_LIMIT     = 20000;   // cycles to wait for outstanding placements
   localparam int HOLD_OFF_CYCLES = 300;     // long receiver stall that backs up the request side

   // index with no register behind it, writes there must change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   // one glyph request as it travels on the request channel
   typedef struct packed {
      logic [20:0] code_point;
      logic        metrics_ok;
      logic [8:0]  box_width;
      logic [8:0]  box_height;
      logic        last_glyph;
   } glyph_t;

   // one placement result
   typedef struct packed {
      logic        placed;
      logic [11:0] place_x;
      logic [12:0] place_y;
      logic [13:0] atlas_height_now;
      logic        build_done;
   } placement_t;

   // shelf packer predictor plus the queue of placements still owed by the block
   class atlas_shelf_scoreboard;
      bit [12:0]   atlas_width;
      bit [12:0]   start_height;
      bit [13:0]   max_height;
      bit [12:0]   pen_x;
      bit [13:0]   pen_y;
      bit [8:0]    row_height;
      bit [13:0]   atlas_height;
      placement_t  pending_placements[$];
      int unsigned mismatches;

      function new();
         atlas_width  = 13'(RESET_ATLAS_WIDTH);
         start_height = 13'(RESET_START_HEIGHT);
         max_height   = 14'(RESET_MAX_HEIGHT);
         mismatches   = 0;
         restart_build();
      endfunction

      // pen back to the corner, atlas back to the start height
      function void restart_build();
         pen_x        = 13'd1;
         pen_y        = 14'd1;
         row_height   = 9'd0;
         atlas_height = 14'(start_height);
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] value);
         case (index)
            CSR_ATLAS_WIDTH:  atlas_width  = value[12:0];
            CSR_START_HEIGHT: start_height = value[12:0];   // used at the next restart
            CSR_MAX_HEIGHT:   max_height   = value;
            default: ;
         endcase
      endfunction

      // next-fit shelf step for one glyph
      function placement_t place_glyph(glyph_t g);
         int unsigned bw, bh, next_y, grown, doublings;
         bit          usable;
         placement_t  p;
         bw = (g.box_width == 0) ? 1 : g.box_width;
         bh = (g.box_height == 0) ? 1 : g.box_height;
         usable = g.metrics_ok && bw <= GASP_MAX_GLYPH_SIDE && bh <= GASP_MAX_GLYPH_SIDE
                  && g.code_point >= FIRST_PRINTABLE;
         p = '0;
         if (usable) begin
            // box runs past the right edge: open a new shelf under the tallest box
            if (pen_x + bw + 1 > atlas_width) begin
               next_y     = pen_y + row_height + 1;
               pen_x      = 13'd1;
               pen_y      = (next_y > PEN_Y_CAP) ? 14'(PEN_Y_CAP) : 14'(next_y);
               row_height = 9'd0;
            end
            // grow the atlas while the box hangs off the bottom, bounded per glyph
            doublings = 0;
            while (doublings < DOUBLE_LIMIT && pen_y + bh + 1 > atlas_height
                   && atlas_height < max_height) begin
               grown        = 32'(atlas_height) * 2;
               atlas_height = (grown > HEIGHT_CAP) ? 14'(HEIGHT_CAP) : 14'(grown);
               doublings++;
            end
            // a rejected glyph keeps the wrap and the growth done for it
            if (pen_y + bh + 1 <= atlas_height) begin
               p.placed  = 1'b1;
               p.place_x = (pen_x > PLACE_X_CAP) ? 12'(PLACE_X_CAP) : pen_x[11:0];
               p.place_y = (pen_y > PLACE_Y_CAP) ? 13'(PLACE_Y_CAP) : pen_y[12:0];
               pen_x     = 13'(pen_x + bw + 1);
               if (bh > row_height)
                  row_height = 9'(bh);
            end
         end
         p.atlas_height_now = atlas_height;
         p.build_done       = g.last_glyph;
         if (g.last_glyph)
            restart_build();
         return p;
      endfunction

      function void note_glyph(glyph_t g);
         pending_placements.push_back(place_glyph(g));
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_placement(placement_t got);
         placement_t want;
         if (pending_placements.size() == 0) begin
            $display("%0t ns: unexpected placement, expected none, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = pending_placements.pop_front();
         compare_field("placed", want.placed, got.placed);
         compare_field("place_x", want.place_x, got.place_x);
         compare_field("place_y", want.place_y, got.place_y);
         compare_field("atlas_height_now", want.atlas_height_now, got.atlas_height_now);
         compare_field("build_done", want.build_done, got.build_done);
      endfunction

      function int unsigned pending_count();
         return pending_placements.size();
      endfunction

      function void report_leftover();
         $display("%0t ns: %0d placements expected, actual none arrived", $time,
                  pending_placements.size());
         mismatches++;
         pending_placements.delete();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata  = '0;
   logic                       req_tuser  = 1'b0;
   logic                       req_tlast  = 1'b0;

   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tlast;

   // idling percentages for the current phase
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // hold-off handshake between the stimulus and the receiver process
   int unsigned holds_asked = 0;
   int unsigned holds_seen  = 0;
   int unsigned hold_left   = 0;

   atlas_shelf_scoreboard board = new();

   glyph_atlas_shelf_packer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // receiver: checks every accepted placement and stalls at random or on a hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_placement(placement_t'{rsp_tuser, rsp_tdata[11:0], rsp_tdata[24:12],
                                               rsp_tdata[38:25], rsp_tlast});
         if (holds_seen != holds_asked) begin
            holds_seen = holds_asked;
            hold_left  = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // drive one request; valid stays high from one request to the next unless idling
   task automatic send_glyph(glyph_t g);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      // code_point[20:0], box_width[29:21], box_height[38:30], zero[39]
      req_tdata  <= {1'b0, g.box_height, g.box_width, g.code_point};
      req_tuser  <= g.metrics_ok;
      req_tlast  <= g.last_glyph;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_glyph(g);
   endtask

   task automatic program_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                   logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      board.set_register(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop requesting, wait for every owed placement, then let the block go idle
   task automatic settle_block();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (board.pending_count() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (board.pending_count() != 0)
         board.report_leftover();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly printable glyphs of the given size ranges, with some skipped or malformed ones
   function automatic glyph_t random_glyph(int wmin, int wmax, int hmin, int hmax,
                                           int last_pct);
      glyph_t g;
      int     noise;
      g.code_point = 21'($urandom_range(32'h1FFFFF, FIRST_PRINTABLE));
      g.metrics_ok = 1'b1;
      g.box_width  = 9'($urandom_range(wmax, wmin));
      g.box_height = 9'($urandom_range(hmax, hmin));
      g.last_glyph = ($urandom_range(99) < last_pct);
      noise = $urandom_range(99);
      if (noise < 3)
         g.code_point = 21'($urandom_range(FIRST_PRINTABLE - 1, 0));   // control codes
      else if (noise < 6)
         g.metrics_ok = 1'b0;
      else if (noise < 8)
         g.box_width = 9'($urandom_range(511, GASP_MAX_GLYPH_SIDE + 1));
      else if (noise < 10)
         g.box_height = 9'($urandom_range(511, GASP_MAX_GLYPH_SIDE + 1));
      else if (noise < 12)
         g.box_width = 9'd0;
      else if (noise < 14)
         g.box_height = 9'd0;
      return g;
   endfunction

   task automatic run_phase(int items, int idle_pct, int stall_pct,
                            logic [CSR_DATA_WIDTH-1:0] width_reg,
                            logic [CSR_DATA_WIDTH-1:0] start_reg,
                            logic [CSR_DATA_WIDTH-1:0] max_reg,
                            int wmin, int wmax, int hmin, int hmax, int last_pct,
                            bit hold_off);
      settle_block();
      program_register(CSR_ATLAS_WIDTH, width_reg);
      program_register(CSR_START_HEIGHT, start_reg);
      program_register(CSR_MAX_HEIGHT, max_reg);
      send_idle_pct  = idle_pct;
      recv_stall_pct <= stall_pct;
      if (hold_off)
         holds_asked <= holds_asked + 1;
      repeat (items)
         send_glyph(random_glyph(wmin, wmax, hmin, hmax, last_pct));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset register values
      send_glyph(glyph_t'{21'd0, 1'b1, 9'd8, 9'd8, 1'b0});          // control code skipped
      send_glyph(glyph_t'{21'd31, 1'b1, 9'd8, 9'd8, 1'b0});         // last control code
      send_glyph(glyph_t'{21'd32, 1'b1, 9'd10, 9'd12, 1'b0});       // first printable
      send_glyph(glyph_t'{21'h1FFFFF, 1'b0, 9'd20, 9'd20, 1'b0});   // metrics failed
      send_glyph(glyph_t'{21'h1FFFFF, 1'b1, 9'd0, 9'd0, 1'b0});     // zero size as 1x1
      send_glyph(glyph_t'{21'd65, 1'b1, 9'd257, 9'd10, 1'b0});      // too wide
      send_glyph(glyph_t'{21'd66, 1'b1, 9'd10, 9'd511, 1'b0});      // too tall
      send_glyph(glyph_t'{21'd67, 1'b1, 9'd511, 9'd511, 1'b0});
      send_glyph(glyph_t'{21'd68, 1'b1, 9'd256, 9'd256, 1'b0});     // several doublings
      send_glyph(glyph_t'{21'd69, 1'b1, 9'd256, 9'd100, 1'b0});     // shelf wrap
      send_glyph(glyph_t'{21'd70, 1'b1, 9'd256, 9'd256, 1'b1});     // wrap, growth, end of build

      // narrowest atlas, start height zero takes effect only after the next restart
      settle_block();
      program_register(CSR_UNUSED, 14'h3FFF);
      program_register(CSR_ATLAS_WIDTH, 14'd64);
      program_register(CSR_START_HEIGHT, 14'd0);
      program_register(CSR_MAX_HEIGHT, 14'd1);
      send_glyph(glyph_t'{21'd40, 1'b1, 9'd10, 9'd10, 1'b1});
      send_glyph(glyph_t'{21'd41, 1'b1, 9'd200, 9'd10, 1'b0});      // zero height never grows
      settle_block();
      program_register(CSR_START_HEIGHT, 14'd1);
      send_glyph(glyph_t'{21'd42, 1'b1, 9'd1, 9'd1, 1'b1});
      send_glyph(glyph_t'{21'd43, 1'b1, 9'd1, 9'd1, 1'b0});         // rejected, no room to grow
      settle_block();
      program_register(CSR_MAX_HEIGHT, 14'd8192);
      send_glyph(glyph_t'{21'd44, 1'b1, 9'd200, 9'd30, 1'b0});      // wider than atlas, column 1
      send_glyph(glyph_t'{21'd45, 1'b1, 9'd256, 9'd256, 1'b1});

      // random phases: items, idle, stall, registers, size ranges, end-of-build rate, hold-off
      run_phase(110, 0, 0, 14'd512, 14'd64, 14'd4096, 1, 256, 1, 256, 4, 1'b1);
      run_phase(100, 77, 0, 14'd64, 14'd1, 14'd8192, 1, 60, 1, 64, 5, 1'b0);
      run_phase(100, 0, 77, 14'd4096, 14'd4096, 14'd1, 1, 256, 1, 256, 5, 1'b0);
      run_phase(100, 36, 36, 14'd300, 14'd16, 14'h3FFF, 1, 128, 1, 128, 3, 1'b0);
      // one long build of tall shelves drives the height to its cap and place_y past 8191
      run_phase(100, 36, 36, 14'd64, 14'h3FFF, 14'h3FFF, 1, 60, 200, 256, 0, 1'b0);
      // very wide shelf carries place_x past 4095
      run_phase(40, 0, 0, 14'h3FFF, 14'd64, 14'h3FFF, 200, 256, 1, 40, 0, 1'b0);
      run_phase(30, 77, 77, 14'd512, 14'd64, 14'd4096, 1, 256, 1, 256, 10, 1'b0);

      settle_block();
      if (board.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
